>>> src/accel_delta_threshold_reporter_assert.svh
// ----------------------------------------------------------------------------
// accel delta threshold reporter assertion macros
// concurrent checks on a clocked implication, same cycle or next cycle
// ----------------------------------------------------------------------------
`ifndef ACCEL_DELTA_THRESHOLD_REPORTER_ASSERT_SVH
`define ACCEL_DELTA_THRESHOLD_REPORTER_ASSERT_SVH

// antecedent and consequent in the same cycle
`define ADTR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adtr check failed");

// consequent in the cycle after the antecedent
`define ADTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adtr check failed");

`endif

>>> src/adtr_pkg.sv
// ----------------------------------------------------------------------------
// adtr_pkg
// shared widths, register indexes, reset values and the settings bundle
// ----------------------------------------------------------------------------
`default_nettype none

package adtr_pkg;

    localparam int WORD_W     = 16;
    localparam int TIME_W     = 63;
    localparam int THR_W      = 14;
    localparam int INTERVAL_W = 10;
    localparam int BATCH_W    = 6;
    localparam int STEP_W     = 24;
    localparam int TICK_W     = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 3;

    localparam int TICKS_PER_MS = 10000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE  = 3'd4;

    localparam int THRESHOLD_RESET = 205;
    localparam int INTERVAL_RESET  = 10;
    localparam int BATCH_RESET     = 1;

    // settings as seen by the datapath
    typedef struct packed {
        logic [THR_W-1:0]  thr_x;
        logic [THR_W-1:0]  thr_y;
        logic [THR_W-1:0]  thr_z;
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] offset;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/adtr_ifs.sv
// ----------------------------------------------------------------------------
// adtr channel interfaces
// valid/ready channels for incoming samples and outgoing reports
// ----------------------------------------------------------------------------
`default_nettype none

interface adtr_sample_if;
    logic                          valid;
    logic                          ready;
    logic [adtr_pkg::WORD_W-1:0]   x_word;
    logic [adtr_pkg::WORD_W-1:0]   y_word;
    logic [adtr_pkg::WORD_W-1:0]   z_word;
    logic                          batch_start;
    logic [adtr_pkg::TIME_W-1:0]   read_time;

    modport source (
        output valid, x_word, y_word, z_word, batch_start, read_time,
        input  ready
    );
    modport sink (
        input  valid, x_word, y_word, z_word, batch_start, read_time,
        output ready
    );
endinterface

interface adtr_report_if #(
    parameter int SAMPLE_BITS = 14
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [adtr_pkg::TIME_W-1:0]   sample_time;

    modport source (
        output valid, accel_x, accel_y, accel_z, sample_time,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, sample_time,
        output ready
    );
endinterface

`default_nettype wire

>>> src/adtr_cfg.sv
// ----------------------------------------------------------------------------
// adtr_cfg
// setting registers plus the derived timestamp step and batch back-offset
// ----------------------------------------------------------------------------
`default_nettype none

module adtr_cfg #(
    parameter int MAX_BATCH = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write_en,
    input  wire  [adtr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [adtr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output adtr_pkg::cfg_t                     cfg
);

    localparam int NM1_W   = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int UNITS_W = adtr_pkg::INTERVAL_W + NM1_W;
    localparam int OFF_W   = UNITS_W + adtr_pkg::TICK_W;

    logic [adtr_pkg::THR_W-1:0]      thr_x_reg;
    logic [adtr_pkg::THR_W-1:0]      thr_y_reg;
    logic [adtr_pkg::THR_W-1:0]      thr_z_reg;
    logic [adtr_pkg::INTERVAL_W-1:0] interval_reg;
    logic [adtr_pkg::BATCH_W-1:0]    batch_reg;
    logic [adtr_pkg::STEP_W-1:0]     step_reg;
    logic [UNITS_W-1:0]              units_reg;
    logic [adtr_pkg::TIME_W-1:0]     offset_reg;
    logic [adtr_pkg::INTERVAL_W-1:0] wr_interval;
    logic [adtr_pkg::BATCH_W-1:0]    wr_batch;

    // samples before the newest one in a batch, zero size read as one, sizes above MAX_BATCH read as MAX_BATCH
    function automatic logic [NM1_W-1:0] batch_back(input logic [adtr_pkg::BATCH_W-1:0] n);
        if (n == '0)
        begin
            return '0;
        end
        else if (32'(n) > 32'(MAX_BATCH))
        begin
            return NM1_W'(MAX_BATCH - 1);
        end
        else
        begin
            return NM1_W'(n - 1'b1);
        end
    endfunction

    assign wr_interval = cfg_data[adtr_pkg::INTERVAL_W-1:0];
    assign wr_batch    = cfg_data[adtr_pkg::BATCH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_x_reg    <= adtr_pkg::THR_W'(adtr_pkg::THRESHOLD_RESET);
            thr_y_reg    <= adtr_pkg::THR_W'(adtr_pkg::THRESHOLD_RESET);
            thr_z_reg    <= adtr_pkg::THR_W'(adtr_pkg::THRESHOLD_RESET);
            interval_reg <= adtr_pkg::INTERVAL_W'(adtr_pkg::INTERVAL_RESET);
            batch_reg    <= adtr_pkg::BATCH_W'(adtr_pkg::BATCH_RESET);
            step_reg     <= adtr_pkg::STEP_W'(adtr_pkg::INTERVAL_RESET
                                              * adtr_pkg::TICKS_PER_MS);
            units_reg    <= UNITS_W'(adtr_pkg::INTERVAL_RESET
                                     * (adtr_pkg::BATCH_RESET - 1));
            offset_reg   <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    adtr_pkg::REG_THRESHOLD_X: thr_x_reg <= cfg_data[adtr_pkg::THR_W-1:0];
                    adtr_pkg::REG_THRESHOLD_Y: thr_y_reg <= cfg_data[adtr_pkg::THR_W-1:0];
                    adtr_pkg::REG_THRESHOLD_Z: thr_z_reg <= cfg_data[adtr_pkg::THR_W-1:0];
                    adtr_pkg::REG_INTERVAL_MS:
                    begin
                        interval_reg <= wr_interval;
                        step_reg     <= adtr_pkg::STEP_W'(wr_interval)
                                        * adtr_pkg::STEP_W'(adtr_pkg::TICKS_PER_MS);
                        units_reg    <= UNITS_W'(wr_interval)
                                        * UNITS_W'(batch_back(batch_reg));
                    end
                    adtr_pkg::REG_BATCH_SIZE:
                    begin
                        batch_reg <= wr_batch;
                        units_reg <= UNITS_W'(interval_reg)
                                     * UNITS_W'(batch_back(wr_batch));
                    end
                    default:
                    begin
                    end
                endcase
            end
            // a write updates units_reg, and the back-offset is registered from units_reg
            offset_reg <= adtr_pkg::TIME_W'(OFF_W'(units_reg)
                                            * OFF_W'(adtr_pkg::TICKS_PER_MS));
        end
    end

    always_comb
    begin
        cfg.thr_x  = thr_x_reg;
        cfg.thr_y  = thr_y_reg;
        cfg.thr_z  = thr_z_reg;
        cfg.step   = step_reg;
        cfg.offset = offset_reg;
    end

endmodule

`default_nettype wire

>>> src/adtr_core.sv
// ----------------------------------------------------------------------------
// adtr_core
// input register, delta test and timestamp logic, report output register
// ----------------------------------------------------------------------------
`default_nettype none

module adtr_core #(
    parameter int SAMPLE_BITS = 14
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire adtr_pkg::cfg_t cfg,
    adtr_sample_if.sink         samples,
    adtr_report_if.source       reports
);

    localparam int CMP_W = (SAMPLE_BITS + 1 > adtr_pkg::THR_W) ? SAMPLE_BITS + 1
                                                                : adtr_pkg::THR_W;

    typedef logic signed [SAMPLE_BITS-1:0] count_t;

    // input stage
    logic                        s1_valid_reg;
    count_t                      s1_x_reg;
    count_t                      s1_y_reg;
    count_t                      s1_z_reg;
    logic                        s1_batch_reg;
    logic [adtr_pkg::TIME_W-1:0] s1_time_reg;

    // running state
    count_t                      last_x_reg;
    count_t                      last_y_reg;
    count_t                      last_z_reg;
    logic                        first_reg;
    logic [adtr_pkg::TIME_W-1:0] next_time_reg;

    // result stage
    logic                        out_valid_reg;
    count_t                      out_x_reg;
    count_t                      out_y_reg;
    count_t                      out_z_reg;
    logic [adtr_pkg::TIME_W-1:0] out_time_reg;

    logic                        accept;
    logic                        report;
    logic                        out_free;
    logic                        advance;
    logic [adtr_pkg::TIME_W-1:0] step_ext;
    logic [adtr_pkg::TIME_W-1:0] item_time;
    logic [adtr_pkg::TIME_W-1:0] next_time_next;

    function automatic count_t count_of(input logic [adtr_pkg::WORD_W-1:0] word);
        return $signed(word[adtr_pkg::WORD_W-1 -: SAMPLE_BITS]);
    endfunction

    function automatic logic moved(input count_t now_v, input count_t last_v,
                                   input logic [adtr_pkg::THR_W-1:0] thr);
        logic signed [SAMPLE_BITS:0] d;
        logic [SAMPLE_BITS:0]        mag;
        d   = {now_v[SAMPLE_BITS-1], now_v} - {last_v[SAMPLE_BITS-1], last_v};
        mag = d[SAMPLE_BITS] ? $unsigned(-d) : $unsigned(d);
        return CMP_W'(mag) >= CMP_W'(thr);
    endfunction

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || reports.ready;
    assign step_ext = adtr_pkg::TIME_W'(cfg.step);

    always_comb
    begin
        report = first_reg
              || moved(s1_x_reg, last_x_reg, cfg.thr_x)
              || moved(s1_y_reg, last_y_reg, cfg.thr_y)
              || moved(s1_z_reg, last_z_reg, cfg.thr_z);
        advance = s1_valid_reg && (!report || out_free);
        // both time values are computed from registered inputs
        if (s1_batch_reg)
        begin
            item_time      = s1_time_reg - cfg.offset;
            next_time_next = s1_time_reg + step_ext - cfg.offset;
        end
        else
        begin
            item_time      = next_time_reg;
            next_time_next = next_time_reg + step_ext;
        end
    end

    assign samples.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_z_reg    <= '0;
            next_time_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                next_time_reg <= next_time_next;
                if (report)
                begin
                    first_reg  <= 1'b0;
                    last_x_reg <= s1_x_reg;
                    last_y_reg <= s1_y_reg;
                    last_z_reg <= s1_z_reg;
                end
            end

            if (advance && report)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (reports.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= count_of(samples.x_word);
            s1_y_reg     <= count_of(samples.y_word);
            s1_z_reg     <= count_of(samples.z_word);
            s1_batch_reg <= samples.batch_start;
            s1_time_reg  <= samples.read_time;
        end
        if (advance && report)
        begin
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_z_reg    <= s1_z_reg;
            out_time_reg <= item_time;
        end
    end

    assign reports.valid       = out_valid_reg;
    assign reports.accel_x     = out_x_reg;
    assign reports.accel_y     = out_y_reg;
    assign reports.accel_z     = out_z_reg;
    assign reports.sample_time = out_time_reg;

endmodule

`default_nettype wire

>>> src/accel_delta_threshold_reporter.sv
// ----------------------------------------------------------------------------
// accel_delta_threshold_reporter: send-on-delta accelerometer report filter
// a sample word is registered in the input stage, its report then in the report output register
// throughput: one sample word per cycle unless a report waits on a stalled output, set by the single compare/time stage
// reset: settings to defaults, first sample after reset always reported
// ----------------------------------------------------------------------------
`default_nettype none

module accel_delta_threshold_reporter #(
    parameter int SAMPLE_BITS = 14,
    parameter int MAX_BATCH   = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write_en,
    input  wire  [adtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [adtr_pkg::CFG_DATA_W-1:0]  cfg_data,
    adtr_sample_if.sink                      samples,
    adtr_report_if.source                    reports
);

    adtr_pkg::cfg_t cfg;

    adtr_cfg #(
        .MAX_BATCH (MAX_BATCH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    adtr_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .reports (reports)
    );

endmodule

`default_nettype wire

>>> src/adtr_checker.sv
// ----------------------------------------------------------------------------
// adtr_checker
// port-level checks on the sample and report channels
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_delta_threshold_reporter_assert.svh"

module adtr_checker (
    input wire            clk,
    input wire            rst_n,
    adtr_sample_if.sink   samples,
    adtr_report_if.source reports
);

    // a held report keeps its word
    `ADTR_ASSERT_NEXT(a_report_hold, clk, rst_n, reports.valid && !reports.ready, reports.valid && $stable(reports.accel_x) && $stable(reports.accel_y) && $stable(reports.accel_z) && $stable(reports.sample_time))

    // a new report always comes from a sample taken through the input register ahead of it
    `ADTR_ASSERT_SAME(a_report_source, clk, rst_n, $rose(reports.valid), $past(samples.valid && samples.ready, 2))

    // input only stalls behind a full, stalled output
    `ADTR_ASSERT_SAME(a_stall_cause, clk, rst_n, !samples.ready, reports.valid && !reports.ready)

endmodule

bind accel_delta_threshold_reporter adtr_checker u_adtr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .reports (reports)
);

`default_nettype wire

>>> tb/accel_delta_threshold_reporter_test.sv
// ----------------------------------------------------------------------------
// accel_delta_threshold_reporter_test
// drives accelerometer sample words through the reporter under changing
// settings and idle patterns, predicts each report and its timestamp, and
// compares every report word against the oldest prediction
// ----------------------------------------------------------------------------
module accel_delta_threshold_reporter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import adtr_pkg::*;

    localparam int SAMPLE_BITS = 14;
    localparam int MAX_BATCH   = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
        logic [WORD_W-1:0] z_word;
        logic              batch_start;
        logic [TIME_W-1:0] read_time;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic [TIME_W-1:0]             stamp;
    } report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    adtr_sample_if smp ();
    adtr_report_if #(.SAMPLE_BITS(SAMPLE_BITS)) rpt ();

    accel_delta_threshold_reporter #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_BATCH  (MAX_BATCH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .samples     (smp),
        .reports     (rpt)
    );

    sample_t pending_samples[$];
    report_t due_reports[$];

    // predictor copy of settings and filter state
    logic [THR_W-1:0]      lim_x, lim_y, lim_z;
    logic [INTERVAL_W-1:0] interval_set;
    logic [BATCH_W-1:0]    batch_set;
    logic signed [SAMPLE_BITS-1:0] held_x, held_y, held_z;
    bit                    first_due;
    logic [TIME_W-1:0]     time_next;

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_start;
    int hold_left;
    int stall_cycles;
    logic [WORD_W-1:0] walk_x, walk_y, walk_z;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit far_enough(input logic signed [SAMPLE_BITS-1:0] now_c,
                                      input logic signed [SAMPLE_BITS-1:0] held_c,
                                      input logic [THR_W-1:0] lim);
        int d;
        begin
            d = int'(now_c) - int'(held_c);
            if (d < 0)
                d = -d;
            return d >= int'(lim);
        end
    endfunction

    function automatic int batch_len();
        begin
            if (batch_set == 0)
                return 1;
            if (int'(batch_set) > MAX_BATCH)
                return MAX_BATCH;
            return int'(batch_set);
        end
    endfunction

    task automatic predict_report(input sample_t s);
        logic signed [SAMPLE_BITS-1:0] cx, cy, cz;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] stamp;
        bit hit;
        report_t r;
        begin
            cx = s.x_word[WORD_W-1 -: SAMPLE_BITS];
            cy = s.y_word[WORD_W-1 -: SAMPLE_BITS];
            cz = s.z_word[WORD_W-1 -: SAMPLE_BITS];
            step = TIME_W'(interval_set) * TIME_W'(TICKS_PER_MS);
            // batch start backdates to the first sample of the batch
            if (s.batch_start)
                stamp = s.read_time - step * TIME_W'(batch_len() - 1);
            else
                stamp = time_next;
            time_next = stamp + step;
            if (first_due)
            begin
                first_due = 1'b0;
                hit = 1'b1;
            end
            else
            begin
                hit = far_enough(cx, held_x, lim_x) || far_enough(cy, held_y, lim_y) ||
                      far_enough(cz, held_z, lim_z);
            end
            if (hit)
            begin
                held_x = cx;
                held_y = cy;
                held_z = cz;
                r.ax = cx;
                r.ay = cy;
                r.az = cz;
                r.stamp = stamp;
                due_reports.push_back(r);
            end
        end
    endtask

    task automatic flag_error(input string what);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, what);
        end
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid       <= 1'b0;
            smp.x_word      <= '0;
            smp.y_word      <= '0;
            smp.z_word      <= '0;
            smp.batch_start <= 1'b0;
            smp.read_time   <= '0;
        end
        else
        begin
            if (smp.valid && smp.ready)
                predict_report(pending_samples.pop_front());
            if (!smp.valid || smp.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    smp.valid       <= 1'b1;
                    smp.x_word      <= pending_samples[0].x_word;
                    smp.y_word      <= pending_samples[0].y_word;
                    smp.z_word      <= pending_samples[0].z_word;
                    smp.batch_start <= pending_samples[0].batch_start;
                    smp.read_time   <= pending_samples[0].read_time;
                end
                else
                begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // report monitor
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            rpt.ready <= 1'b0;
        end
        else
        begin
            if (rpt.valid && rpt.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    flag_error($sformatf("unexpected report x=%0d y=%0d z=%0d t=%0d",
                               rpt.accel_x, rpt.accel_y, rpt.accel_z, rpt.sample_time));
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (rpt.accel_x !== want.ax || rpt.accel_y !== want.ay ||
                        rpt.accel_z !== want.az || rpt.sample_time !== want.stamp)
                        flag_error($sformatf(
                            "report exp x=%0d y=%0d z=%0d t=%0d got x=%0d y=%0d z=%0d t=%0d",
                            want.ax, want.ay, want.az, want.stamp,
                            rpt.accel_x, rpt.accel_y, rpt.accel_z, rpt.sample_time));
                end
            end
            rpt.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with work outstanding but no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp.valid && smp.ready) || (rpt.valid && rpt.ready))
                stall_cycles <= 0;
            else if (pending_samples.size() != 0 || due_reports.size() != 0)
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("accel_delta_threshold_reporter: mismatch");
                $finish;
            end
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        begin
            @(posedge clk);
            cfg_write_en <= 1'b1;
            cfg_index    <= idx;
            cfg_data     <= data;
            case (idx)
                REG_THRESHOLD_X: lim_x = data[THR_W-1:0];
                REG_THRESHOLD_Y: lim_y = data[THR_W-1:0];
                REG_THRESHOLD_Z: lim_z = data[THR_W-1:0];
                REG_INTERVAL_MS: interval_set = data[INTERVAL_W-1:0];
                REG_BATCH_SIZE:  batch_set = data[BATCH_W-1:0];
                default: ;
            endcase
            @(posedge clk);
            cfg_write_en <= 1'b0;
        end
    endtask

    task automatic set_limits(input int lx, input int ly, input int lz);
        begin
            set_reg(REG_THRESHOLD_X, CFG_DATA_W'(lx));
            set_reg(REG_THRESHOLD_Y, CFG_DATA_W'(ly));
            set_reg(REG_THRESHOLD_Z, CFG_DATA_W'(lz));
        end
    endtask

    task automatic push_sample(input logic [WORD_W-1:0] xw, input logic [WORD_W-1:0] yw,
                               input logic [WORD_W-1:0] zw, input bit start,
                               input logic [TIME_W-1:0] rt);
        sample_t s;
        begin
            s.x_word = xw;
            s.y_word = yw;
            s.z_word = zw;
            s.batch_start = start;
            s.read_time = rt;
            pending_samples.push_back(s);
        end
    endtask

    // axis word for a given count, low bits random
    function automatic logic [WORD_W-1:0] count_word(input int c);
        logic [31:0] cv;
        begin
            cv = c;
            return {cv[SAMPLE_BITS-1:0], 2'($urandom_range(0, 3))};
        end
    endfunction

    // mostly small wanders around the previous word, sometimes a jump anywhere
    function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] prev);
        begin
            if ($urandom_range(0, 9) < 3)
                return WORD_W'($urandom);
            return prev + WORD_W'($urandom_range(0, 3200)) - WORD_W'(1600);
        end
    endfunction

    task automatic drain();
        begin
            while (pending_samples.size() != 0 || due_reports.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic queue_random(input int count);
        int made;
        int n;
        int i;
        bit start;
        logic [TIME_W-1:0] rt;
        begin
            made = 0;
            while (made < count)
            begin
                // mostly whole batches of the configured size
                if ($urandom_range(0, 4) != 0)
                    n = batch_len();
                else
                    n = $urandom_range(1, 6);
                for (i = 0; i < n && made < count; i++)
                begin
                    walk_x = next_word(walk_x);
                    walk_y = next_word(walk_y);
                    walk_z = next_word(walk_z);
                    case ($urandom_range(0, 3))
                        0: rt = TIME_W'($urandom_range(0, 50000));
                        1: rt = ~TIME_W'($urandom_range(0, 50000));
                        default: rt = TIME_W'({$urandom, $urandom});
                    endcase
                    start = (i == 0);
                    if ($urandom_range(0, 19) == 0)
                        start = !start;
                    push_sample(walk_x, walk_y, walk_z, start, rt);
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        smp.valid       = 1'b0;
        smp.x_word      = '0;
        smp.y_word      = '0;
        smp.z_word      = '0;
        smp.batch_start = 1'b0;
        smp.read_time   = '0;
        rpt.ready       = 1'b0;
        hold_start      = 1'b0;
        hold_left       = 0;
        stall_cycles    = 0;
        mismatches      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        walk_x = '0;
        walk_y = '0;
        walk_z = '0;
        lim_x = THR_W'(THRESHOLD_RESET);
        lim_y = THR_W'(THRESHOLD_RESET);
        lim_z = THR_W'(THRESHOLD_RESET);
        interval_set = INTERVAL_W'(INTERVAL_RESET);
        batch_set = BATCH_W'(BATCH_RESET);
        held_x = '0;
        held_y = '0;
        held_z = '0;
        first_due = 1'b1;
        time_next = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first sample, threshold edges on each axis, time wrap
        push_sample(16'h8000, 16'h7FFF, 16'h0000, 1'b1, '0);
        push_sample(16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0);
        push_sample(count_word(-8192 + 204), 16'h7FFF, 16'h0000, 1'b0, '0);
        push_sample(count_word(-8192 + 205), 16'h7FFF, 16'h0000, 1'b0, '0);
        push_sample(count_word(-7987), count_word(8191 - 205), 16'h0001, 1'b0, '0);
        push_sample(count_word(-7987), count_word(7986), count_word(-205), 1'b0, '0);
        push_sample(count_word(-7987), count_word(7986), count_word(-1), 1'b0, '0);
        push_sample(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, {TIME_W{1'b1}});
        push_sample(16'h0000, 16'h0000, 16'h7FFF, 1'b0, '0);
        drain();

        // ignored register indexes, zero interval, zero batch size
        set_reg(3'd5, 14'h3FFF);
        set_reg(3'd7, 14'h0000);
        set_reg(REG_INTERVAL_MS, 14'd0);
        set_reg(REG_BATCH_SIZE, 14'd0);
        @(negedge clk);
        push_sample(16'h8000, 16'h8000, 16'h8000, 1'b1, TIME_W'(123));
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, TIME_W'(999));
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, TIME_W'(77));
        drain();

        // oversized batch saturates, a full-width interval write keeps its low bits, backdating wraps backward
        set_reg(REG_INTERVAL_MS, 14'h3FFF);
        set_reg(REG_BATCH_SIZE, 14'd63);
        @(negedge clk);
        push_sample(16'h0000, 16'h0000, 16'h0000, 1'b1, TIME_W'(5));
        push_sample(16'h4000, 16'hC000, 16'h0004, 1'b0, '0);
        push_sample(16'hFFFC, 16'h3FFC, 16'h8000, 1'b0, '0);
        drain();

        set_limits($urandom_range(100, 400), $urandom_range(100, 400), $urandom_range(100, 400));
        set_reg(REG_INTERVAL_MS, 14'd1000);
        set_reg(REG_BATCH_SIZE, 14'd32);
        @(negedge clk);
        queue_random(150);
        drain();

        set_limits(0, 0, 0);
        set_reg(REG_INTERVAL_MS, 14'd1);
        set_reg(REG_BATCH_SIZE, 14'd1);
        @(negedge clk);
        send_idle_pct = 48;
        queue_random(120);
        drain();

        set_limits($urandom_range(50, 400), $urandom_range(50, 400), $urandom_range(50, 400));
        set_reg(REG_INTERVAL_MS, CFG_DATA_W'($urandom_range(1, 1000)));
        set_reg(REG_BATCH_SIZE, CFG_DATA_W'($urandom_range(0, 63)));
        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        queue_random(150);
        drain();

        set_limits(16383, 300, 16383);
        set_reg(REG_INTERVAL_MS, 14'd0);
        set_reg(REG_BATCH_SIZE, 14'd0);
        @(negedge clk);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        queue_random(120);
        drain();

        // receiver holds off while samples keep coming
        set_limits(100, 100, 100);
        set_reg(REG_INTERVAL_MS, 14'd1023);
        set_reg(REG_BATCH_SIZE, 14'd33);
        @(negedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(160);
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("accel_delta_threshold_reporter: match");
        else
            $display("accel_delta_threshold_reporter: mismatch");
        $finish;
    end

endmodule

>>> accel_delta_threshold_reporter.f
+incdir+src
src/adtr_pkg.sv
src/adtr_ifs.sv
src/adtr_cfg.sv
src/adtr_core.sv
src/accel_delta_threshold_reporter.sv
src/adtr_checker.sv
tb/accel_delta_threshold_reporter_test.sv
